// ----- sv/imf_pkg.sv -----
package imf_pkg;

  // default geometry
  localparam int IMF_KERNEL_SIZE = 5;
  localparam int IMF_MAX_WIDTH   = 2048;

  // queue between front and back
  localparam int IMF_QUEUE_DEPTH = 4;

  // configuration register map
  localparam int          IMF_CFG_AW      = 1;
  localparam int          IMF_CFG_DW      = 12;
  localparam logic [0:0]  IMF_REG_WIDTH   = 1'b0;
  localparam logic [0:0]  IMF_REG_HEIGHT  = 1'b1;
  localparam logic [11:0] IMF_WIDTH_RST   = 12'd640;
  localparam logic [11:0] IMF_HEIGHT_RST  = 12'd480;

  // result side information carried alongside the window
  typedef struct packed {
    logic        done;
    logic [10:0] col;
    logic [11:0] row;
  } imf_meta_t;

endpackage

// ----- sv/imf_ram.sv -----
module imf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port; read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/imf_front.sv -----
module imf_front #(
  parameter int KERNEL_SIZE = imf_pkg::IMF_KERNEL_SIZE,
  parameter int MAX_WIDTH   = imf_pkg::IMF_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [imf_pkg::IMF_CFG_AW-1:0]        cfg_addr,
  input  logic [imf_pkg::IMF_CFG_DW-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            pixel,
  input  logic                                  frame_start,
  input  logic                                  room,
  output logic                                  push,
  output logic [KERNEL_SIZE*KERNEL_SIZE*8-1:0]  push_win,
  output imf_pkg::imf_meta_t                    push_meta
);
  import imf_pkg::*;

  localparam int KAREA  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int NLINES = KERNEL_SIZE - 1;
  localparam int EDGE   = KERNEL_SIZE / 2;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int LW     = 8 * NLINES;

  logic [11:0]       width_r, height_r;
  logic [11:0]       row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [12:0]       w_eff;
  logic [11:0]       h_eff;
  logic              accept;
  logic [11:0]       r;
  logic [CW-1:0]     c;
  logic [12:0]       c13, c_inc;
  logic [12:0]       r_inc;
  logic              emit_a, done_a;
  logic [CW:0]       ccol;
  imf_meta_t         meta_a;

  logic              b_valid_r, b_emit_r;
  logic [7:0]        b_px_r;
  logic [CW-1:0]     b_addr_r;
  imf_meta_t         b_meta_r;
  logic              fwd_r, fwd_nxt;
  logic [LW-1:0]     fwd_data_r;
  logic [LW-1:0]     ram_q, old_lines, new_lines;
  logic [KAREA*8-1:0] window_r, window_nxt;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMF_WIDTH_RST;
      height_r <= IMF_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        IMF_REG_WIDTH:  width_r  <= cfg_wdata;
        IMF_REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp the width to MAX_WIDTH and force a zero width or height to one
  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = 13'd1;
    end else if ({1'b0, width_r} > 13'(MAX_WIDTH)) begin
      w_eff = 13'(MAX_WIDTH);
    end else begin
      w_eff = {1'b0, width_r};
    end
    h_eff = (height_r == 12'd0) ? 12'd1 : height_r;
  end

  assign in_ready = room;
  assign accept   = in_valid && room;

  // classify the incoming word by its position
  always_comb begin
    r      = frame_start ? 12'd0 : row_r;
    c      = frame_start ? '0 : col_r;
    c13    = 13'(c);
    c_inc  = c13 + 13'd1;
    r_inc  = {1'b0, r} + 13'd1;
    emit_a = (r >= 12'(KERNEL_SIZE - 1)) && (c13 >= 13'(KERNEL_SIZE - 1)) &&
             (r < h_eff) && (c13 < w_eff);
    done_a = (r == h_eff - 12'd1) && (c13 == w_eff - 13'd1);
    ccol   = {1'b0, c} - (CW + 1)'(EDGE);
    meta_a.row  = r - 12'(EDGE);
    meta_a.col  = 11'(ccol);
    meta_a.done = done_a;
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= {1'b0, h_eff}) ? 12'd0 : r_inc[11:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r;
    end
  end

  // advance the position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 12'd0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line buffer: all older rows of one column in one word
  imf_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_addr_r),
    .wdata (new_lines),
    .re    (accept),
    .raddr (c),
    .rdata (ram_q)
  );

  assign old_lines = fwd_r ? fwd_data_r : ram_q;
  assign new_lines = {b_px_r, old_lines[LW-1:8]};
  assign fwd_nxt   = accept && b_valid_r && (b_addr_r == c);

  // hold the word for the second front stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      b_valid_r <= accept;
      fwd_r     <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_emit_r   <= emit_a;
      b_px_r     <= pixel;
      b_addr_r   <= c;
      b_meta_r   <= meta_a;
      fwd_data_r <= new_lines;
    end
  end

  // shift the window left and insert the new column
  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      for (int x = 0; x + 1 < KERNEL_SIZE; x++) begin
        window_nxt[8*(k*KERNEL_SIZE+x)+:8] = window_r[8*(k*KERNEL_SIZE+x+1)+:8];
      end
      if (k < NLINES) begin
        window_nxt[8*(k*KERNEL_SIZE+KERNEL_SIZE-1)+:8] = old_lines[8*k+:8];
      end else begin
        window_nxt[8*(k*KERNEL_SIZE+KERNEL_SIZE-1)+:8] = b_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      window_r <= window_nxt;
    end
  end

  assign push      = b_valid_r && b_emit_r;
  assign push_win  = window_nxt;
  assign push_meta = b_meta_r;

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(b_valid_r))
    else $error("line bypass without a write in flight");

endmodule

// ----- sv/imf_fifo.sv -----
module imf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = imf_pkg::IMF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CNW-1:0]   count_r;

  // store a word at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_r] <= din;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNW'(1);
      end
    end
  end

  assign dout  = data_r[rd_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNW'(DEPTH));
  assign count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");

endmodule

// ----- sv/imf_back.sv -----
module imf_back #(
  parameter int KERNEL_SIZE = imf_pkg::IMF_KERNEL_SIZE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*8-1:0] q_win,
  input  imf_pkg::imf_meta_t                   q_meta,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_median,
  output imf_pkg::imf_meta_t                   out_meta
);
  import imf_pkg::*;

  localparam int KAREA = KERNEL_SIZE * KERNEL_SIZE;
  localparam int W     = KAREA * 8;
  localparam int NST   = KAREA;

  // one odd-even transposition layer
  function automatic logic [W-1:0] cx_layer(input logic [W-1:0] x, input int par);
    logic [W-1:0] y;
    logic [7:0]   a, b;
    y = x;
    for (int i = par; i + 1 < KAREA; i += 2) begin
      a = x[8*i+:8];
      b = x[8*(i+1)+:8];
      y[8*i+:8]     = (a < b) ? a : b;
      y[8*(i+1)+:8] = (a < b) ? b : a;
    end
    return y;
  endfunction

  logic             en;
  logic             v_r    [NST];
  logic [W-1:0]     vals_r [NST];
  imf_meta_t        meta_r [NST];

  // whole network moves unless the result register is held
  assign en    = !v_r[NST-1] || out_ready;
  assign q_pop = en && q_valid;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [W-1:0] stg_in;
    logic         stg_v;
    imf_meta_t    stg_meta;

    if (s == 0) begin : g_first
      assign stg_in   = q_win;
      assign stg_v    = q_valid;
      assign stg_meta = q_meta;
    end else begin : g_rest
      assign stg_in   = vals_r[s-1];
      assign stg_v    = v_r[s-1];
      assign stg_meta = meta_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= stg_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vals_r[s] <= cx_layer(stg_in, s % 2);
        meta_r[s] <= stg_meta;
      end
    end
  end

  assign out_valid  = v_r[NST-1];
  assign out_median = vals_r[NST-1][8*(KAREA/2)+:8];
  assign out_meta   = meta_r[NST-1];

endmodule

// ----- sv/image_median_filter_2d.sv -----
// Channel  Dir  Fields (low bit up)
// in_      in   tdata: pixel_value[7:0]; tuser: frame_start
// out_     out  tdata: median_value[7:0], center_row[19:8], center_col[30:20], 0;
//               tlast: frame_done
// cfg_     in   cfg_addr 0 image_width, 1 image_height; cfg_wdata 12 bits
//
// One pixel per clock sustained while in_tready is high. A result becomes valid after
// its pixel is accepted: the front stage loads at the accepting edge, the queue
// after that, then KERNEL_SIZE^2 sorting-network stages.
// The line buffer is a single-port-write RAM, one word per column.
// rst_n is synchronous; the line buffer and window are not cleared.
// A held result stalls the sorter; input keeps flowing while the queue still has
// a free slot for the word in the front stage.
module image_median_filter_2d #(
  parameter int KERNEL_SIZE = imf_pkg::IMF_KERNEL_SIZE,
  parameter int MAX_WIDTH   = imf_pkg::IMF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [imf_pkg::IMF_CFG_AW-1:0] cfg_addr,
  input  logic [imf_pkg::IMF_CFG_DW-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // pixel_value
  input  logic                           in_tuser,   // frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // median_value, center_row, center_col
  output logic                           out_tlast
);
  import imf_pkg::*;

  localparam int KAREA = KERNEL_SIZE * KERNEL_SIZE;
  localparam int QW    = KAREA * 8 + $bits(imf_meta_t);
  localparam int QCW   = $clog2(IMF_QUEUE_DEPTH + 1);

  logic               room, push, pop, q_empty, q_full;
  logic [KAREA*8-1:0] push_win, q_win;
  imf_meta_t          push_meta, q_meta, res_meta;
  logic [QCW-1:0]     q_count;
  logic [QW-1:0]      q_dout;
  logic [7:0]         res_median;

  // reserve a slot for the word in the second front stage
  assign room = ({1'b0, q_count} + (QCW + 1)'(push)) < (QCW + 1)'(IMF_QUEUE_DEPTH);

  imf_front #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pixel       (in_tdata),
    .frame_start (in_tuser),
    .room        (room),
    .push        (push),
    .push_win    (push_win),
    .push_meta   (push_meta)
  );

  imf_fifo #(.WIDTH(QW), .DEPTH(IMF_QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({push_meta, push_win}),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  assign q_win  = q_dout[KAREA*8-1:0];
  assign q_meta = q_dout[QW-1:KAREA*8];

  imf_back #(.KERNEL_SIZE(KERNEL_SIZE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_win      (q_win),
    .q_meta     (q_meta),
    .q_pop      (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_median (res_median),
    .out_meta   (res_meta)
  );

  assign out_tdata = {1'b0, res_meta.col, res_meta.row, res_median};
  assign out_tlast = res_meta.done;

  a_room_matches_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !q_full)
    else $error("input ready while queue full");

endmodule
